>>> design/qscq_pkg.sv
package qscq_pkg;

    // Field widths of the transaction payloads.
    localparam int COEF_W   = 13;
    localparam int LEVEL_W  = 14;
    localparam int QUAL_W   = 7;
    localparam int POS_W    = 6;

    // Step division: numerator up to 12150, divisor up to 100.
    localparam int SNUM_W   = 14;
    localparam int SDEN_W   = 7;
    // Level division: numerator up to 4266, divisor (step) up to 341.
    localparam int TNUM_W   = 13;
    localparam int STEP_W   = 9;

    localparam int BASE_W   = 7;

    localparam logic [QUAL_W-1:0] QUALITY_RESET = 7'd100;
    localparam logic [QUAL_W-1:0] QUALITY_SPLIT = 7'd50;
    localparam logic [QUAL_W-1:0] QUALITY_MAX   = 7'd100;
    localparam logic [QUAL_W-1:0] SCALE_DIV     = 7'd100;
    localparam logic [QUAL_W-1:0] ROUND_ADD     = 7'd50;
    localparam logic [7:0]        SCALE_TOP     = 8'd200;

    localparam logic [STEP_W-1:0] STEP_MAX      = 9'd341;
    localparam logic [STEP_W-1:0] DC_SOFT_LIMIT = 9'd8;
    localparam logic [STEP_W-1:0] AC_SOFT_LIMIT = 9'd24;

    // Base quantization tables, stored in zigzag order.
    localparam logic [BASE_W-1:0] LUMA_BASE [64] = '{
        7'd16, 7'd11, 7'd12, 7'd14, 7'd12, 7'd10, 7'd16, 7'd14,
        7'd13, 7'd14, 7'd18, 7'd17, 7'd16, 7'd19, 7'd24, 7'd40,
        7'd26, 7'd24, 7'd22, 7'd22, 7'd24, 7'd49, 7'd35, 7'd37,
        7'd29, 7'd40, 7'd58, 7'd51, 7'd61, 7'd60, 7'd57, 7'd51,
        7'd56, 7'd55, 7'd64, 7'd72, 7'd92, 7'd78, 7'd64, 7'd68,
        7'd87, 7'd69, 7'd55, 7'd56, 7'd80, 7'd109, 7'd81, 7'd87,
        7'd95, 7'd98, 7'd103, 7'd104, 7'd103, 7'd62, 7'd77, 7'd113,
        7'd121, 7'd112, 7'd100, 7'd120, 7'd92, 7'd101, 7'd103, 7'd99
    };

    localparam logic [BASE_W-1:0] CHROMA_BASE [64] = '{
        7'd17, 7'd18, 7'd18, 7'd24, 7'd21, 7'd24, 7'd47, 7'd26,
        7'd26, 7'd47, 7'd99, 7'd66, 7'd56, 7'd66, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    // Base step for one table and zigzag position.
    function automatic logic [BASE_W-1:0] base_step(input logic sel,
                                                     input logic [POS_W-1:0] pos);
        base_step = sel ? CHROMA_BASE[pos] : LUMA_BASE[pos];
    endfunction

endpackage

>>> design/qscq_div_cell.sv
// One cell of a restoring divider chain. Each cell settles one quotient bit:
// the top numerator bit is shifted into the partial remainder, the divisor is
// subtracted when it fits, and the quotient bit enters the numerator from the
// bottom. After as many cells as the numerator has bits, the numerator
// register holds the quotient.
module qscq_div_cell
    import qscq_pkg::*;
#(
    parameter int NUM_W  = SNUM_W,
    parameter int DEN_W  = SDEN_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DEN_W-1:0]  out_rem,
    output logic [NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // Trial subtraction for one quotient bit.
    always_comb begin
        trial    = {in_rem, in_num[NUM_W-1]};
        diff     = trial - {1'b0, in_den};
        fits     = (trial >= {1'b0, in_den});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {in_num[NUM_W-2:0], fits};
    end

    // Valid flag of the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Payload moves to the next cell whenever the chain advances.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

>>> design/quality_scaled_coefficient_quantizer.sv
// An accepted input transaction passes one input stage, a 14-cell step divider,
// a step shaping stage, a 13-cell level divider and the output register.
// Throughput: one transaction per cycle while the skid stage is empty; every
// divider cell settles one bit.
// Reset (aresetn low at a clock edge) empties the pipeline and sets quality
// to 100.
module quality_scaled_coefficient_quantizer
    import qscq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      quality_we,
    input  logic [QUAL_W-1:0]         quality_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COEF_W-1:0]  s_coefficient,
    input  logic                      s_table_select,
    input  logic [POS_W-1:0]          s_position,
    input  logic                      s_last_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [LEVEL_W-1:0] m_level,
    output logic                      m_last_out
);

    localparam int A_CELLS  = SNUM_W;
    localparam int B_CELLS  = TNUM_W;
    localparam int A_SIDE_W = COEF_W + 4;
    localparam int B_SIDE_W = 2;

    logic en;

    // Quality register.
    logic [QUAL_W-1:0] quality_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_reg <= QUALITY_RESET;
        end else if (quality_we) begin
            quality_reg <= quality_wdata;
        end
    end

    // Input stage: scaled numerator and divisor of the step, coefficient
    // magnitude and position class.
    logic [QUAL_W-1:0]   q_eff;
    logic [QUAL_W-1:0]   factor;
    logic [QUAL_W-1:0]   addend;
    logic [SDEN_W-1:0]   den_next;
    logic [SNUM_W-1:0]   num_next;
    logic [BASE_W-1:0]   base;
    logic [COEF_W-1:0]   coef_u;
    logic [COEF_W-1:0]   mag;
    logic                neg;
    logic                is_dc;
    logic                is_ac_low;
    logic [A_SIDE_W-1:0] side_next;

    always_comb begin
        q_eff  = (quality_reg == '0) ? QUAL_W'(1) : quality_reg;
        base   = base_step(s_table_select, s_position);
        if (q_eff < QUALITY_SPLIT) begin
            factor   = SCALE_DIV;
            addend   = q_eff;
            den_next = {q_eff[QUAL_W-2:0], 1'b0};
        end else if (q_eff <= QUALITY_MAX) begin
            factor   = QUAL_W'(SCALE_TOP - {q_eff, 1'b0});
            addend   = ROUND_ADD;
            den_next = SCALE_DIV;
        end else begin
            factor   = '0;
            addend   = '0;
            den_next = SCALE_DIV;
        end
        num_next  = SNUM_W'(base) * SNUM_W'(factor) + SNUM_W'(addend);
        coef_u    = s_coefficient;
        neg       = coef_u[COEF_W-1];
        mag       = neg ? (~coef_u + COEF_W'(1)) : coef_u;
        is_dc     = (s_position == '0);
        is_ac_low = (s_position == POS_W'(1)) || (s_position == POS_W'(2));
        side_next = {mag, neg, is_dc, is_ac_low, s_last_in};
    end

    logic                p0_valid_reg;
    logic [SNUM_W-1:0]   p0_num_reg;
    logic [SDEN_W-1:0]   p0_den_reg;
    logic [A_SIDE_W-1:0] p0_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_num_reg  <= num_next;
            p0_den_reg  <= den_next;
            p0_side_reg <= side_next;
        end
    end

    // Step divider chain.
    logic                a_valid [0:A_CELLS];
    logic [SDEN_W-1:0]   a_rem   [0:A_CELLS];
    logic [SNUM_W-1:0]   a_num   [0:A_CELLS];
    logic [SDEN_W-1:0]   a_den   [0:A_CELLS];
    logic [A_SIDE_W-1:0] a_side  [0:A_CELLS];

    assign a_valid[0] = p0_valid_reg;
    assign a_rem[0]   = '0;
    assign a_num[0]   = p0_num_reg;
    assign a_den[0]   = p0_den_reg;
    assign a_side[0]  = p0_side_reg;

    for (genvar i = 0; i < A_CELLS; i++) begin : g_step_div
        qscq_div_cell #(
            .NUM_W  (SNUM_W),
            .DEN_W  (SDEN_W),
            .SIDE_W (A_SIDE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (a_valid[i]),
            .in_rem    (a_rem[i]),
            .in_num    (a_num[i]),
            .in_den    (a_den[i]),
            .in_side   (a_side[i]),
            .out_valid (a_valid[i+1]),
            .out_rem   (a_rem[i+1]),
            .out_num   (a_num[i+1]),
            .out_den   (a_den[i+1]),
            .out_side  (a_side[i+1])
        );
    end

    // Step shaping: clamp, soften the lowest positions, add half the step.
    logic [SNUM_W-1:0] raw_step;
    logic [STEP_W-1:0] step_clamped;
    logic [STEP_W-1:0] step_final;
    logic [STEP_W:0]   step_sum;
    logic [COEF_W-1:0] a_mag;
    logic              a_neg;
    logic              a_dc;
    logic              a_ac_low;
    logic              a_last;
    logic [TNUM_W-1:0] t_next;

    always_comb begin
        raw_step = a_num[A_CELLS];
        {a_mag, a_neg, a_dc, a_ac_low, a_last} = a_side[A_CELLS];
        if (raw_step == '0) begin
            step_clamped = STEP_W'(1);
        end else if (raw_step > SNUM_W'(STEP_MAX)) begin
            step_clamped = STEP_MAX;
        end else begin
            step_clamped = raw_step[STEP_W-1:0];
        end
        step_final = step_clamped;
        step_sum   = '0;
        if (a_dc && (step_clamped > DC_SOFT_LIMIT)) begin
            step_sum   = {1'b0, step_clamped} + {1'b0, AC_SOFT_LIMIT};
            step_final = STEP_W'(step_sum >> 2);
        end else if (a_ac_low && (step_clamped > AC_SOFT_LIMIT)) begin
            step_sum   = {1'b0, step_clamped} + {1'b0, AC_SOFT_LIMIT};
            step_final = STEP_W'(step_sum >> 1);
        end
        t_next = a_mag + TNUM_W'(step_final >> 1);
    end

    logic                p1_valid_reg;
    logic [TNUM_W-1:0]   p1_t_reg;
    logic [STEP_W-1:0]   p1_step_reg;
    logic [B_SIDE_W-1:0] p1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= a_valid[A_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_t_reg    <= t_next;
            p1_step_reg <= step_final;
            p1_side_reg <= {a_neg, a_last};
        end
    end

    // Level divider chain.
    logic                b_valid [0:B_CELLS];
    logic [STEP_W-1:0]   b_rem   [0:B_CELLS];
    logic [TNUM_W-1:0]   b_num   [0:B_CELLS];
    logic [STEP_W-1:0]   b_den   [0:B_CELLS];
    logic [B_SIDE_W-1:0] b_side  [0:B_CELLS];

    assign b_valid[0] = p1_valid_reg;
    assign b_rem[0]   = '0;
    assign b_num[0]   = p1_t_reg;
    assign b_den[0]   = p1_step_reg;
    assign b_side[0]  = p1_side_reg;

    for (genvar j = 0; j < B_CELLS; j++) begin : g_level_div
        qscq_div_cell #(
            .NUM_W  (TNUM_W),
            .DEN_W  (STEP_W),
            .SIDE_W (B_SIDE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (b_valid[j]),
            .in_rem    (b_rem[j]),
            .in_num    (b_num[j]),
            .in_den    (b_den[j]),
            .in_side   (b_side[j]),
            .out_valid (b_valid[j+1]),
            .out_rem   (b_rem[j+1]),
            .out_num   (b_num[j+1]),
            .out_den   (b_den[j+1]),
            .out_side  (b_side[j+1])
        );
    end

    // Sign restore. A quotient of zero already covers a sum below the step.
    logic [LEVEL_W-1:0] level_next;
    logic               last_next;
    logic               end_valid;

    always_comb begin
        if (b_side[B_CELLS][1]) begin
            level_next = LEVEL_W'(0) - {1'b0, b_num[B_CELLS]};
        end else begin
            level_next = {1'b0, b_num[B_CELLS]};
        end
        last_next = b_side[B_CELLS][0];
        end_valid = b_valid[B_CELLS];
    end

    // Output register with a skid stage: the chain keeps moving while the result
    // channel stalls, until a result has to wait in the skid stage.
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_last_reg;
    logic               skid_valid_reg;
    logic [LEVEL_W-1:0] skid_level_reg;
    logic               skid_last_reg;
    logic               m_free;

    assign m_free = !m_valid_reg || m_ready;
    assign en     = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_free) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (m_free) begin
            m_valid_reg <= end_valid;
        end else if (end_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_free) begin
                m_level_reg <= skid_level_reg;
                m_last_reg  <= skid_last_reg;
            end
        end else if (m_free) begin
            m_level_reg <= level_next;
            m_last_reg  <= last_next;
        end else begin
            skid_level_reg <= level_next;
            skid_last_reg  <= last_next;
        end
    end

    assign s_ready    = en;
    assign m_valid    = m_valid_reg;
    assign m_level    = m_level_reg;
    assign m_last_out = m_last_reg;

endmodule

>>> tb/tb_quality_scaled_coefficient_quantizer.sv
module tb_quality_scaled_coefficient_quantizer
    import qscq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 120;
    // Hold-offs start early in the phases that run without idle gaps, so the
    // sender keeps offering transactions until the pipeline is full.
    localparam int HOLD_SPACING   = 200;
    localparam int FIRST_HOLD_AT  = 120;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 50;
    localparam int BLOCK_SIZE     = 64;

    // Step limits used when shaping the scaled step, and the quality split.
    localparam int STEP_CEIL      = 341;
    localparam int DC_KNEE        = 8;
    localparam int AC_KNEE        = 24;
    localparam int QUALITY_MID    = 50;

    // Qualities for the random phases; later phases draw one at random.
    localparam int FIXED_QUALITY [9] = '{0, 127, 50, 49, 101, 100, 1, 75, 25};

    // Standard base steps in zigzag order.
    localparam int LUMA_Q [64] = '{
        16, 11, 12, 14, 12, 10, 16, 14, 13, 14, 18, 17, 16, 19, 24, 40,
        26, 24, 22, 22, 24, 49, 35, 37, 29, 40, 58, 51, 61, 60, 57, 51,
        56, 55, 64, 72, 92, 78, 64, 68, 87, 69, 55, 56, 80, 109, 81, 87,
        95, 98, 103, 104, 103, 62, 77, 113, 121, 112, 100, 120, 92, 101, 103, 99
    };
    localparam int CHROMA_Q [64] = '{
        17, 18, 18, 24, 21, 24, 47, 26, 26, 47, 99, 66, 56, 66, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99,
        99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99, 99
    };

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              table_select;
        logic [POS_W-1:0]  position;
        logic              last_in;
    } coef_txn_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last_out;
    } level_txn_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      quality_we = 1'b0;
    logic [QUAL_W-1:0]         quality_wdata = QUALITY_RESET;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COEF_W-1:0]  s_coefficient = '0;
    logic                      s_table_select = 1'b0;
    logic [POS_W-1:0]          s_position = '0;
    logic                      s_last_in = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [LEVEL_W-1:0] m_level;
    logic                      m_last_out;

    coef_txn_t  pending_coefs[$];
    level_txn_t expected_levels[$];
    logic [QUAL_W-1:0] quality_now = QUALITY_RESET;
    bit  idle_en = 1'b1;
    bit  in_taken = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_left = 0;
    int  next_hold_at = FIRST_HOLD_AT;
    int  queued_count = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  quiet_cycles = 0;
    int  error_count = 0;

    quality_scaled_coefficient_quantizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .quality_we     (quality_we),
        .quality_wdata  (quality_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coefficient  (s_coefficient),
        .s_table_select (s_table_select),
        .s_position     (s_position),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level        (m_level),
        .m_last_out     (m_last_out)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Quantizer step for one table, position and quality, with clamping and
    // the softening of the DC term and the first two AC terms.
    function automatic int quant_step(input logic chroma, input logic [POS_W-1:0] pos,
                                      input logic [QUAL_W-1:0] qual);
        int base;
        int q;
        int s;
        base = chroma ? CHROMA_Q[pos] : LUMA_Q[pos];
        q = (qual == 0) ? 1 : int'(qual);
        if (q < QUALITY_MID)
            s = (100 * base + q) / (2 * q);
        else
            s = (base * (200 - 2 * q) + 50) / 100;
        if (s < 1)
            s = 1;
        if (s > STEP_CEIL)
            s = STEP_CEIL;
        if (pos == 0) begin
            if (s > DC_KNEE)
                s = (s + 3 * DC_KNEE) / 4;
        end else if (pos <= 2) begin
            if (s > AC_KNEE)
                s = (s + AC_KNEE) / 2;
        end
        return s;
    endfunction

    // Rounded quantization of one coefficient; small magnitudes go to zero.
    function automatic level_txn_t quantize(input coef_txn_t txn, input logic [QUAL_W-1:0] qual);
        level_txn_t r;
        int s;
        int value;
        int mag;
        int t;
        int lvl;
        s = quant_step(txn.table_select, txn.position, qual);
        value = int'($signed(txn.coefficient));
        mag = (value < 0) ? -value : value;
        t = mag + (s >>> 1);
        lvl = (t >= s) ? t / s : 0;
        if (value < 0)
            lvl = -lvl;
        r.level = lvl[LEVEL_W-1:0];
        r.last_out = txn.last_in;
        return r;
    endfunction

    // Idle length between transactions: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_coef(input int value, input logic chroma, input int pos,
                              input logic last);
        coef_txn_t txn;
        txn.coefficient = value[COEF_W-1:0];
        txn.table_select = chroma;
        txn.position = pos[POS_W-1:0];
        txn.last_in = last;
        pending_coefs.push_back(txn);
        queued_count++;
    endtask

    task automatic wait_drained();
        wait (accepted_count == queued_count && checked_count == accepted_count);
    endtask

    // Quality is only written once the pipeline has emptied.
    task automatic set_quality(input int q);
        @(negedge aclk);
        quality_we <= 1'b1;
        quality_wdata <= q[QUAL_W-1:0];
        @(negedge aclk);
        quality_we <= 1'b0;
        quality_now = q[QUAL_W-1:0];
    endtask

    // Input driver: holds each transaction until it is accepted.
    always @(negedge aclk) begin : coef_driver
        coef_txn_t txn;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap--;
            end else if (pending_coefs.size() != 0) begin
                txn = pending_coefs.pop_front();
                s_coefficient <= txn.coefficient;
                s_table_select <= txn.table_select;
                s_position <= txn.position;
                s_last_in <= txn.last_in;
                s_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs that back up the pipeline.
    always @(negedge aclk) begin : level_receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (accepted_count >= next_hold_at) begin
            m_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += HOLD_SPACING;
        end else if (out_gap > 0) begin
            m_ready <= 1'b0;
            out_gap--;
        end else begin
            m_ready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    // Check each result transaction and predict each accepted input transaction.
    always @(posedge aclk) begin : level_checker
        level_txn_t want;
        coef_txn_t  taken;
        bit         out_taken;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_valid && s_ready;
            out_taken = m_valid && m_ready;
            if (out_taken) begin
                checked_count++;
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result level %0d last %0b",
                             $time, m_level, m_last_out);
                    error_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_level !== want.level) begin
                        $display("%0t: level mismatch: expected %0d, got %0d",
                                 $time, $signed(want.level), m_level);
                        error_count++;
                    end
                    if (m_last_out !== want.last_out) begin
                        $display("%0t: last_out mismatch: expected %0b, got %0b",
                                 $time, want.last_out, m_last_out);
                        error_count++;
                    end
                end
            end
            if (in_taken) begin
                taken.coefficient = s_coefficient;
                taken.table_select = s_table_select;
                taken.position = s_position;
                taken.last_in = s_last_in;
                expected_levels.push_back(quantize(taken, quality_now));
                accepted_count++;
            end
            if (in_taken || out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Ends a run in which the block stops moving transactions.
    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL quality_scaled_coefficient_quantizer");
        $finish;
    end

    initial begin : stimulus
        int blk_pos;
        int q;
        int value;
        int pos;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset quality gives a step of one: extremes pass through unchanged,
        // including the most negative coefficient.
        queue_coef(4095, 1'b0, 0, 1'b0);
        queue_coef(-4096, 1'b0, 0, 1'b0);
        queue_coef(0, 1'b0, 3, 1'b0);
        queue_coef(1, 1'b1, 63, 1'b0);
        queue_coef(-1, 1'b1, 1, 1'b0);
        queue_coef(4095, 1'b1, 2, 1'b0);
        queue_coef(-4096, 1'b1, 5, 1'b1);
        wait_drained();

        // Lowest quality: the step saturates and softening applies on the
        // first three positions; values straddle the rounding threshold.
        set_quality(1);
        queue_coef(4095, 1'b0, 0, 1'b0);
        queue_coef(-4096, 1'b0, 0, 1'b1);
        queue_coef(-4096, 1'b1, 1, 1'b0);
        queue_coef(4095, 1'b0, 2, 1'b0);
        queue_coef(170, 1'b0, 63, 1'b0);
        queue_coef(171, 1'b0, 63, 1'b0);
        queue_coef(-171, 1'b1, 63, 1'b0);
        queue_coef(-170, 1'b1, 40, 1'b1);
        queue_coef(4095, 1'b1, 63, 1'b0);
        queue_coef(-4096, 1'b0, 45, 1'b0);
        wait_drained();

        // Random phases: mostly coefficients walking through blocks in zigzag
        // order, with some scattered positions and a wide mix of magnitudes.
        blk_pos = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < $size(FIXED_QUALITY))
                q = FIXED_QUALITY[ph];
            else
                q = $urandom_range(1, 100);
            set_quality(q);
            idle_en = (ph % 4) != 2;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: value = int'($urandom_range(0, 600)) - 300;
                    4, 5, 6, 7: value = int'($urandom_range(0, 8191));
                    8: value = int'($urandom_range(0, 80)) - 40;
                    default: value = $urandom_range(0, 1) ? -4096 : 4095;
                endcase
                pos = ($urandom_range(0, 9) < 7) ? blk_pos : int'($urandom_range(0, 63));
                queue_coef(value, 1'($urandom_range(0, 1)), pos,
                           $urandom_range(0, 19) == 0);
                blk_pos = (blk_pos + 1) % BLOCK_SIZE;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS quality_scaled_coefficient_quantizer");
        else
            $display("FAIL quality_scaled_coefficient_quantizer");
        $finish;
    end

endmodule
